>>> src/fixed_length_frame_deframer_defines.svh
// Assertion macros for the fixed-length frame deframer.
// Included by RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef FIXED_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define FIXED_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define FLFD_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// cons must hold in the cycle after ante
`define FLFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define FLFD_ASSERT_ALWAYS(lbl, expr)
`define FLFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/flfd_pkg.sv
// Shared types and constants for the fixed-length frame deframer.
// No dependencies.
package flfd_pkg;

	localparam logic [7:0] FRAME_OPEN  = 8'hAA;
	localparam logic [7:0] FRAME_CLOSE = 8'h55;
	localparam int unsigned OVERFLOW_MARGIN = 10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRAME,
		ST_OVF,
		ST_DRAIN
	} flfd_state_t;

	typedef enum logic {
		CMP_FRAME,
		CMP_OVF
	} cmp_sel_t;

endpackage

>>> src/flfd_cmp.sv
// Shared threshold comparator for the byte count.
// Depends on flfd_pkg; thresholds derive from the frame and buffer sizes.
module flfd_cmp import flfd_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = 12,
	parameter int unsigned BUFFER_BYTES  = 256,
	localparam int unsigned CW = $clog2(BUFFER_BYTES + 1)
) (
	input  logic [CW-1:0] count,
	input  cmp_sel_t      sel,
	output logic          gt
);

	localparam logic [CW-1:0] FRAME_MIN = CW'(PAYLOAD_BYTES + 1);
	localparam logic [CW-1:0] OVF_LIM   = CW'(BUFFER_BYTES - OVERFLOW_MARGIN);

	logic [CW-1:0] thresh;

	always_comb begin
		case (sel)
			CMP_FRAME: thresh = FRAME_MIN;
			CMP_OVF:   thresh = OVF_LIM;
			default:   thresh = OVF_LIM;
		endcase
	end

	assign gt = count > thresh;

endmodule

>>> src/fixed_length_frame_deframer.sv
// Fixed-length frame deframer top level.
// Depends on flfd_pkg, flfd_cmp and fixed_length_frame_deframer_defines.svh.
//
// Usage:
//   s_* : received serial bytes, one per transaction (s_tdata = rx_byte).
//   m_* : payload bytes of each validated frame, in arrival order;
//         m_tlast marks the final payload byte (m_tdata = payload_byte).
//   A frame is an 0xAA byte, PAYLOAD_BYTES payload bytes, then 0x55, all
//   received since the last count clear. The count clears on a frame and
//   when it passes BUFFER_BYTES-10 without one.
// Timing:
//   A byte that closes no frame passes accept, frame check and overflow
//   check, both checks through the one shared comparator.
//   A closing byte passes accept and frame check, then one payload byte is
//   loaded into the output register per cycle while m_tready does not stall
//   the drain. The first payload byte shows on m_tdata after the first drain step.
//   s_tready is high only while the sequencer is idle.
// Reset: count cleared, output register empty, sequencer idle.
// Stall: a held m_tready freezes the drain; the last payload byte may wait
//   in the output register while the next input byte is accepted.
`include "fixed_length_frame_deframer_defines.svh"

module fixed_length_frame_deframer import flfd_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = 12,
	parameter int unsigned BUFFER_BYTES  = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic       m_tlast
);

	localparam int unsigned CW    = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned HIST  = PAYLOAD_BYTES + 1;
	localparam int unsigned RW    = $clog2(PAYLOAD_BYTES + 1);
	localparam logic [CW-1:0] OVF_TOP = CW'(BUFFER_BYTES - OVERFLOW_MARGIN + 1);

	flfd_state_t state_q, state_nxt;

	logic [CW-1:0] cnt_q;
	logic [7:0]    byte_q;
	logic [RW-1:0] rem_q;
	logic [7:0]    hist_q [HIST];

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	logic       in_acc;
	logic       slot_free;
	logic       load_out;
	logic       shift_hist;
	logic       cmp_gt;
	logic       frame_hit;
	cmp_sel_t   cmp_sel;

	assign in_acc    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;

	flfd_cmp #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_cmp (
		.count(cnt_q),
		.sel  (cmp_sel),
		.gt   (cmp_gt)
	);

	assign frame_hit = cmp_gt && (byte_q == FRAME_CLOSE) && (hist_q[0] == FRAME_OPEN);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_nxt = ST_FRAME;
			ST_FRAME: state_nxt = frame_hit ? ST_DRAIN : ST_OVF;
			ST_OVF:   state_nxt = ST_IDLE;
			ST_DRAIN: if (slot_free && rem_q == RW'(1)) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		cmp_sel    = CMP_FRAME;
		load_out   = 1'b0;
		shift_hist = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_FRAME: cmp_sel = CMP_FRAME;
			ST_OVF: begin
				cmp_sel    = CMP_OVF;
				shift_hist = 1'b1;
			end
			ST_DRAIN: begin
				load_out   = slot_free;
				shift_hist = slot_free;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_FRAME && frame_hit) begin
				cnt_q <= '0;
				rem_q <= RW'(PAYLOAD_BYTES);
			end
			if (state_q == ST_OVF && cmp_gt) cnt_q <= '0;
			if (load_out) begin
				rem_q       <= rem_q - RW'(1);
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) byte_q <= s_tdata;
		if (load_out) begin
			out_data_q <= hist_q[1];
			out_last_q <= (rem_q == RW'(1));
		end
	end

	// history shift line; during the drain the payload walks past tap 1,
	// the history left behind is never used since the count was cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST; i++) hist_q[i] <= '0;
		end else if (shift_hist) begin
			for (int i = 0; i < HIST - 1; i++) hist_q[i] <= hist_q[i + 1];
			hist_q[HIST-1] <= byte_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`FLFD_ASSERT_ALWAYS(a_drain_rem, (state_q != ST_DRAIN) || (rem_q != '0))
	`FLFD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= OVF_TOP)
	`FLFD_ASSERT_NEXT(a_acc_check, in_acc, state_q == ST_FRAME)
	`FLFD_ASSERT_NEXT(a_frame_clear, (state_q == ST_FRAME) && frame_hit, cnt_q == '0)

endmodule
